[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the execute unit sources
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

[rtl/mre_pkg.sv]
// ---------------------------------------------------------------------------
// mre_pkg
// Shared types and constants of the execute unit.
// ---------------------------------------------------------------------------
package mre_pkg;
	localparam int unsigned NumRegs  = 32;
	localparam int unsigned MemWords = 1024;
	localparam int unsigned RegW     = $clog2(NumRegs);
	localparam int unsigned MemAw    = $clog2(MemWords);
	localparam int unsigned LenW     = 17;
	localparam logic [LenW-1:0] LenReset = 17'h10000;
	localparam logic [4:0] ShamtMask = 5'h1F;

	typedef enum logic [4:0] {
		OP_ADD = 5'd0, OP_ADDI = 5'd1, OP_SUB = 5'd2, OP_MUL = 5'd3,
		OP_DIV = 5'd4, OP_MOD = 5'd5, OP_AND = 5'd6, OP_OR = 5'd7,
		OP_XOR = 5'd8, OP_SLL = 5'd9, OP_SRL = 5'd10, OP_LW = 5'd11,
		OP_SW = 5'd12, OP_BEQ = 5'd13, OP_BNE = 5'd14, OP_BLT = 5'd15,
		OP_BGE = 5'd16, OP_JAL = 5'd17, OP_JALR = 5'd18, OP_HALT = 5'd19,
		OP_PRINT = 5'd20
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CLEAR, ST_READ, ST_EXEC, ST_DIV, ST_MEM, ST_OUT
	} state_t;

	// divider start request and result
	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
		logic [31:0] rem;
	} div_rsp_t;
endpackage

[rtl/mre_divider.sv]
// ---------------------------------------------------------------------------
// mre_divider
// Signed restoring divider, one quotient bit per cycle, with operand and
// sign fix-up. Zero divisor gives zero quotient and remainder.
// ---------------------------------------------------------------------------
module mre_divider
	import mre_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  mre_pkg::div_req_t  req,
	output mre_pkg::div_rsp_t  rsp
);
	`include "assert_macros.svh"

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [31:0] quo_q, rem_q, dvs_q;
	logic        negq_q, negr_q, zero_q, fix_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			fix_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == 6'd31) begin
				busy_q <= 1'b0;
				fix_q  <= 1'b1;
			end
			cnt_q <= cnt_q + 6'd1;
		end else begin
			fix_q <= 1'b0;
		end
	end

	// datapath: magnitudes in, shift-subtract, sign fix at the end
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q  <= req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
			dvs_q  <= req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
			rem_q  <= '0;
			negq_q <= req.dividend[31] ^ req.divisor[31];
			negr_q <= req.dividend[31];
			zero_q <= (req.divisor == 32'd0);
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_comb begin
		rsp.done = fix_q;
		rsp.quo  = zero_q ? 32'd0 : (negq_q ? (32'd0 - quo_q) : quo_q);
		rsp.rem  = zero_q ? 32'd0 : (negr_q ? (32'd0 - rem_q) : rem_q);
	end

	`ASSERT_IMPLIES(a_no_busy_fix, clk, arst_n, fix_q, !busy_q)
	`ASSERT_NEXT(a_start_busy, clk, arst_n, req.start, busy_q)
	`ASSERT_IMPLIES(a_cnt_range, clk, arst_n, busy_q, cnt_q < 6'd32)
endmodule

[rtl/mini_risc_execute_unit.sv]
// ---------------------------------------------------------------------------
// mini_risc_execute_unit
// Executes one decoded instruction per input beat and returns one result beat.
// ---------------------------------------------------------------------------
// One instruction at a time. Register file and data memory are synchronous
// RAMs with registered reads: an instruction passes accept, read, execute
// and output, lw and sw add a memory access state, div and mod a state that
// waits for the bit-serial divider. After reset a clearing pass over all
// 1024 words zeroes the data memory (registers are cleared in the same
// pass) before the first beat is taken; configuration writes are taken
// throughout. The result sits in an output register, so the next beat may
// enter while it waits.
module mini_risc_execute_unit
	import mre_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [mre_pkg::LenW-1:0]  cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [4:0]                cmd,
	input  logic [4:0]                dest_reg,
	input  logic [4:0]                src_reg_a,
	input  logic [4:0]                src_reg_b,
	input  logic signed [31:0]        immediate,
	input  logic                      restart,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [31:0]               next_pc,
	output logic                      halted,
	output logic                      writeback_valid,
	output logic [4:0]                writeback_reg,
	output logic signed [31:0]        writeback_value,
	output logic                      print_valid,
	output logic signed [31:0]        print_value
);
	`include "assert_macros.svh"

	state_t state_q, state_d;
	logic [LenW-1:0]  plen_q;
	logic [31:0]      pc_q;
	logic             run_q;
	logic [MemAw:0]   clr_q;

	// captured instruction
	logic [4:0]  op_q, rd_q, ra_q, rb_q;
	logic [31:0] imm_q;

	// memories
	logic [31:0] rf_a [NumRegs];
	logic [31:0] rf_b [NumRegs];
	logic [31:0] dmem [MemWords];
	logic [31:0] a_rd, b_rd, m_rd;

	// result register
	logic        ov_q;
	logic [31:0] npc_q, wbv_q, pv_q;
	logic        hlt_q, wbe_q, pe_q;
	logic [4:0]  wbr_q;

	logic        in_acc, out_acc, res_done;
	logic        ex_go, skip;
	logic [31:0] val, nxt, addr;
	logic        wr, stop, prn;
	logic        rf_we;
	logic [RegW-1:0] rf_wa;
	logic [31:0] rf_wd;
	logic        dm_we;
	logic [MemAw-1:0] dm_wa;
	logic [31:0] dm_wd;
	div_req_t    dreq;
	div_rsp_t    drsp;

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;

	mre_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == (MemAw+1)'(MemWords - 1))
					state_d = ST_IDLE;
			ST_IDLE:  if (in_acc) state_d = ST_READ;
			ST_READ:  state_d = ST_EXEC;
			ST_EXEC: begin
				if (skip) state_d = ST_OUT;
				else if (op_q == OP_DIV || op_q == OP_MOD) state_d = ST_DIV;
				else if (op_q == OP_LW || op_q == OP_SW) state_d = ST_MEM;
				else state_d = ST_OUT;
			end
			ST_DIV:   if (drsp.done) state_d = ST_OUT;
			ST_MEM:   state_d = ST_OUT;
			ST_OUT:   if (!ov_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	// outputs of the sequencer
	assign in_ready = (state_q == ST_IDLE);
	assign ex_go    = (state_q == ST_EXEC);
	assign dreq.start    = ex_go && !skip && (op_q == OP_DIV || op_q == OP_MOD);
	assign dreq.dividend = a_rd;
	assign dreq.divisor  = b_rd;
	assign res_done = (state_q == ST_OUT) && (!ov_q || out_ready);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) plen_q <= LenReset;
		else if (cfg_valid && cfg_ready) plen_q <= cfg_data;
	end

	// capture the instruction beat; restart is applied with the pc
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= cmd;
			rd_q  <= dest_reg;
			ra_q  <= src_reg_a;
			rb_q  <= src_reg_b;
			imm_q <= immediate;
		end
	end

	assign skip = !run_q || ({15'd0, plen_q} <= pc_q);
	assign addr = a_rd + imm_q;

	// execute
	always_comb begin
		val  = '0;
		wr   = 1'b0;
		stop = 1'b0;
		prn  = 1'b0;
		nxt  = pc_q + 32'd1;
		case (op_q)
			OP_ADD:  begin val = a_rd + b_rd; wr = 1'b1; end
			OP_ADDI: begin val = a_rd + imm_q; wr = 1'b1; end
			OP_SUB:  begin val = a_rd - b_rd; wr = 1'b1; end
			OP_MUL:  begin val = a_rd * b_rd; wr = 1'b1; end
			OP_DIV:  wr = 1'b1;
			OP_MOD:  wr = 1'b1;
			OP_AND:  begin val = a_rd & b_rd; wr = 1'b1; end
			OP_OR:   begin val = a_rd | b_rd; wr = 1'b1; end
			OP_XOR:  begin val = a_rd ^ b_rd; wr = 1'b1; end
			OP_SLL:  begin val = a_rd << (b_rd[4:0] & ShamtMask); wr = 1'b1; end
			OP_SRL:  begin val = a_rd >> (b_rd[4:0] & ShamtMask); wr = 1'b1; end
			OP_LW:   wr = 1'b1;
			OP_SW:   ;
			OP_BEQ:  if (a_rd == b_rd) nxt = pc_q + imm_q;
			OP_BNE:  if (a_rd != b_rd) nxt = pc_q + imm_q;
			OP_BLT:  if ($signed(a_rd) < $signed(b_rd)) nxt = pc_q + imm_q;
			OP_BGE:  if (!($signed(a_rd) < $signed(b_rd))) nxt = pc_q + imm_q;
			OP_JAL:  begin val = pc_q + 32'd1; wr = 1'b1; nxt = imm_q; end
			OP_JALR: begin val = pc_q + 32'd1; wr = 1'b1; nxt = a_rd + imm_q; end
			OP_HALT: stop = 1'b1;
			OP_PRINT: prn = 1'b1;
			default: stop = 1'b1;
		endcase
	end

	// pc, run flag and pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			run_q <= 1'b0;
			ov_q  <= 1'b0;
		end else begin
			if (in_acc && restart) begin
				pc_q  <= '0;
				run_q <= 1'b1;
			end
			if (ex_go) begin
				if (skip) run_q <= 1'b0;
				else begin
					pc_q <= nxt;
					if (stop || ({15'd0, plen_q} <= nxt)) run_q <= 1'b0;
				end
			end
			if (res_done) ov_q <= 1'b1;
			else if (out_acc) ov_q <= 1'b0;
		end
	end

	// result payload, built up over exec / div / mem
	logic [31:0] rwbv_q;
	logic        rhlt_q, rwbe_q, rpe_q;
	logic [31:0] rnpc_q, rpv_q;
	always_ff @(posedge clk) begin
		if (ex_go) begin
			rnpc_q <= skip ? pc_q : nxt;
			rhlt_q <= skip || stop || ({15'd0, plen_q} <= nxt);
			rwbe_q <= !skip && wr && (rd_q != 5'd0);
			rwbv_q <= val;
			rpe_q  <= !skip && prn;
			rpv_q  <= (!skip && prn) ? a_rd : 32'd0;
		end else if (state_q == ST_DIV && drsp.done) begin
			rwbv_q <= (op_q == OP_DIV) ? drsp.quo : drsp.rem;
		end else if (state_q == ST_MEM && op_q == OP_LW) begin
			rwbv_q <= m_rd;
		end
		if (res_done) begin
			npc_q <= rnpc_q;
			hlt_q <= rhlt_q;
			wbe_q <= rwbe_q;
			wbr_q <= rwbe_q ? rd_q : 5'd0;
			wbv_q <= rwbe_q ? rwbv_q : 32'd0;
			pe_q  <= rpe_q;
			pv_q  <= rpv_q;
		end
	end

	// register file: two read ports, written at result time or during clear
	logic [31:0] a_raw_q, b_raw_q;
	logic        ra_z_q, rb_z_q, ld_ok_q;
	assign rf_we = (state_q == ST_CLEAR) || (res_done && rwbe_q);
	assign rf_wa = (state_q == ST_CLEAR) ? clr_q[RegW-1:0] : rd_q;
	assign rf_wd = (state_q == ST_CLEAR) ? 32'd0 : rwbv_q;
	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_a[rf_wa] <= rf_wd;
			rf_b[rf_wa] <= rf_wd;
		end
		a_raw_q <= rf_a[ra_q];
		b_raw_q <= rf_b[rb_q];
		ra_z_q  <= (ra_q == 5'd0);
		rb_z_q  <= (rb_q == 5'd0);
	end
	assign a_rd = ra_z_q ? 32'd0 : a_raw_q;
	assign b_rd = rb_z_q ? 32'd0 : b_raw_q;

	// data memory: address formed in exec, bounds-checked and accessed in the memory state
	logic [31:0] addr_q, bst_q, m_raw_q;
	always_ff @(posedge clk) begin
		if (ex_go) begin
			addr_q <= addr;
			bst_q  <= b_rd;
		end
		if (dm_we) dmem[dm_wa] <= dm_wd;
		m_raw_q <= dmem[addr[MemAw-1:0]];
		ld_ok_q <= (addr < 32'(MemWords));
	end
	assign m_rd  = ld_ok_q ? m_raw_q : 32'd0;
	assign dm_we = (state_q == ST_CLEAR) ||
		(state_q == ST_MEM && op_q == OP_SW && addr_q < 32'(MemWords));
	assign dm_wa = (state_q == ST_CLEAR) ? clr_q[MemAw-1:0] : addr_q[MemAw-1:0];
	assign dm_wd = (state_q == ST_CLEAR) ? 32'd0 : bst_q;

	assign out_valid       = ov_q;
	assign next_pc         = npc_q;
	assign halted          = hlt_q;
	assign writeback_valid = wbe_q;
	assign writeback_reg   = wbr_q;
	assign writeback_value = wbv_q;
	assign print_valid     = pe_q;
	assign print_value     = pv_q;

	`ASSERT_IMPLIES(a_ready_idle, clk, arst_n, in_ready, state_q == ST_IDLE)
	`ASSERT_NEXT(a_res_valid, clk, arst_n, res_done, out_valid)
	`ASSERT_IMPLIES(a_wb_nonzero, clk, arst_n, out_valid && writeback_valid, writeback_reg != 5'd0)
	`ASSERT_IMPLIES(a_no_clr_write, clk, arst_n, state_q == ST_CLEAR, !in_ready)
endmodule

[tb/mini_risc_execute_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mini_risc_execute_unit_tb
// Self-checking bench for the execute unit. Instructions are driven over the
// input channel, and an instruction-set predictor works out the expected
// result beat for each accepted one. Results are checked in order. Three
// phases run with different idle patterns and program lengths.
// ----------------------------------------------------------------------------
module mini_risc_execute_unit_tb;
	import mre_pkg::*;

	typedef struct packed {
		logic [4:0]  cmd;
		logic [4:0]  rd;
		logic [4:0]  ra;
		logic [4:0]  rb;
		logic [31:0] imm;
		logic        restart;
	} instr_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        halted;
		logic        wb_valid;
		logic [4:0]  wb_reg;
		logic [31:0] wb_value;
		logic        prn_valid;
		logic [31:0] prn_value;
	} result_t;

	// instruction-set predictor and in-order result checker
	class exec_scoreboard;
		logic [31:0] regs [NumRegs];
		logic [31:0] mem [MemWords];
		logic [31:0] pc;
		bit          running;
		logic [31:0] prog_len;
		result_t     pending_q [$];
		int          mismatches;
		int          checked;

		function new();
			foreach (regs[i]) regs[i] = '0;
			foreach (mem[i]) mem[i] = '0;
			pc = '0;
			running = 0;
			prog_len = 32'(LenReset);
			mismatches = 0;
			checked = 0;
		endfunction

		function logic [63:0] sdivmod(logic [31:0] a, logic [31:0] b);
			logic [31:0] ma, mb, q, r;
			if (b == 0) return '0;
			ma = a[31] ? -a : a;
			mb = b[31] ? -b : b;
			q = ma / mb;
			r = ma % mb;
			if (a[31] ^ b[31]) q = -q;
			if (a[31]) r = -r;
			return {q, r};
		endfunction

		// returns 1 when the instruction was executed rather than ignored
		function bit note_instr(instr_t it);
			result_t     res;
			logic [31:0] a, b, nxt, val, addr;
			logic [63:0] qr;
			bit          wr, stop, prn;
			res = '0;
			val = '0;
			wr = 0;
			stop = 0;
			prn = 0;
			if (it.restart) begin
				pc = '0;
				running = 1;
			end
			if (!running || pc >= prog_len) begin
				running = 0;
				res.next_pc = pc;
				res.halted = 1;
				pending_q.push_back(res);
				return 0;
			end
			a = regs[it.ra];
			b = regs[it.rb];
			nxt = pc + 1;
			addr = a + it.imm;
			case (it.cmd)
				OP_ADD:  begin val = a + b; wr = 1; end
				OP_ADDI: begin val = a + it.imm; wr = 1; end
				OP_SUB:  begin val = a - b; wr = 1; end
				OP_MUL:  begin val = a * b; wr = 1; end
				OP_DIV:  begin qr = sdivmod(a, b); val = qr[63:32]; wr = 1; end
				OP_MOD:  begin qr = sdivmod(a, b); val = qr[31:0]; wr = 1; end
				OP_AND:  begin val = a & b; wr = 1; end
				OP_OR:   begin val = a | b; wr = 1; end
				OP_XOR:  begin val = a ^ b; wr = 1; end
				OP_SLL:  begin val = a << (b[4:0] & ShamtMask); wr = 1; end
				OP_SRL:  begin val = a >> (b[4:0] & ShamtMask); wr = 1; end
				OP_LW:   begin val = (addr < MemWords) ? mem[addr] : '0; wr = 1; end
				OP_SW:   if (addr < MemWords) mem[addr] = b;
				OP_BEQ:  if (a == b) nxt = pc + it.imm;
				OP_BNE:  if (a != b) nxt = pc + it.imm;
				OP_BLT:  if ($signed(a) < $signed(b)) nxt = pc + it.imm;
				OP_BGE:  if ($signed(a) >= $signed(b)) nxt = pc + it.imm;
				OP_JAL:  begin val = pc + 1; wr = 1; nxt = it.imm; end
				OP_JALR: begin val = pc + 1; wr = 1; nxt = a + it.imm; end
				OP_HALT: stop = 1;
				OP_PRINT: prn = 1;
				default: stop = 1;
			endcase
			if (wr && it.rd != 0) begin
				regs[it.rd] = val;
				res.wb_valid = 1;
				res.wb_reg = it.rd;
				res.wb_value = val;
			end
			if (prn) begin
				res.prn_valid = 1;
				res.prn_value = a;
			end
			if (stop || nxt >= prog_len) running = 0;
			pc = nxt;
			res.next_pc = nxt;
			res.halted = !running;
			pending_q.push_back(res);
			return 1;
		endfunction

		function void check_result(result_t got);
			result_t exp_res;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat with nothing expected: %p", $time, got);
				return;
			end
			exp_res = pending_q.pop_front();
			checked++;
			if (got !== exp_res) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result mismatch", $time);
					$display("  expected %p", exp_res);
					$display("  actual   %p", got);
				end
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [LenW-1:0] cfg_data = '0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [4:0]  cmd = '0;
	logic [4:0]  dest_reg = '0;
	logic [4:0]  src_reg_a = '0;
	logic [4:0]  src_reg_b = '0;
	logic signed [31:0] immediate = '0;
	logic        restart = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [31:0] next_pc;
	logic        halted;
	logic        writeback_valid;
	logic [4:0]  writeback_reg;
	logic signed [31:0] writeback_value;
	logic        print_valid;
	logic signed [31:0] print_value;

	exec_scoreboard sb = new();
	int  idle_mode = 0;     // 0: sender 22 %, receiver 76 %; 1: swapped; 2: none
	bit  hold_req = 0;
	int  hold_cnt = 0;
	int  executed = 0;
	int  cfg_writes = 0;

	mini_risc_execute_unit i_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

	// receiver: random stalls, long hold-off on request, result checking
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready)
				sb.check_result({next_pc, halted, writeback_valid, writeback_reg,
					writeback_value, print_valid, print_value});
			if (hold_req && hold_cnt == 0) begin
				hold_cnt <= 400;
				hold_req <= 0;
				out_ready <= 0;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				out_ready <= (hold_cnt == 1);
			end else begin
				case (idle_mode)
					0: out_ready <= ($urandom_range(99) >= 76);
					1: out_ready <= ($urandom_range(99) >= 22);
					default: out_ready <= 1;
				endcase
			end
		end
	end

	task automatic send_instr(instr_t it);
		int pct;
		pct = (idle_mode == 0) ? 22 : (idle_mode == 1) ? 76 : 0;
		while ($urandom_range(99) < pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		cmd <= it.cmd;
		dest_reg <= it.rd;
		src_reg_a <= it.ra;
		src_reg_b <= it.rb;
		immediate <= it.imm;
		restart <= it.restart;
		do @(posedge clk); while (!in_ready);
		if (sb.note_instr(it)) executed++;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending_q.size() != 0) @(posedge clk);
	endtask

	// program length may only change with the unit idle
	task automatic write_prog_len(logic [LenW-1:0] len);
		drain();
		repeat (40) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= len;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.prog_len = 32'(len);
		cfg_writes++;
	endtask

	function automatic instr_t mk(logic [4:0] c, logic [4:0] d, logic [4:0] a,
			logic [4:0] b, logic [31:0] imm, logic rs);
		return '{cmd: c, rd: d, ra: a, rb: b, imm: imm, restart: rs};
	endfunction

	function automatic logic [31:0] rand_imm(logic [4:0] c);
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom();
			3: return -1;
			default:
				if (c >= OP_BEQ && c <= OP_BGE) return $urandom_range(16) - 8;
				else return $urandom_range(MemWords + 8);
		endcase
	endfunction

	// mostly running programs, some illegal opcodes and idle steps
	function automatic instr_t rand_instr();
		instr_t it;
		it.cmd = ($urandom_range(99) < 4) ? 5'($urandom_range(31, 21))
			: 5'($urandom_range(20));
		if (it.cmd == OP_HALT && $urandom_range(3) != 0) it.cmd = OP_ADDI;
		it.rd = 5'($urandom_range(31));
		it.ra = ((it.cmd == OP_LW || it.cmd == OP_SW) && $urandom_range(1))
			? 5'd0 : 5'($urandom_range(31));
		it.rb = 5'($urandom_range(31));
		it.imm = rand_imm(it.cmd);
		if (!sb.running) it.restart = ($urandom_range(9) != 0);
		else it.restart = ($urandom_range(49) == 0);
		return it;
	endfunction

	initial begin
		instr_t  dir_q [$];
		instr_t  it;
		int      n;
		repeat (5) @(posedge clk);
		arst_n <= 1;

		write_prog_len(LenW'(LenReset));

		// directed: extreme operands, every operation, corner cases
		dir_q = '{
			mk(OP_ADDI, 1, 0, 0, 32'h7FFF_FFFF, 1),
			mk(OP_ADDI, 2, 0, 0, 32'h8000_0000, 0),
			mk(OP_ADDI, 3, 0, 0, 32'hFFFF_FFFF, 0),
			mk(OP_ADD, 4, 1, 3, 0, 0),
			mk(OP_SUB, 5, 2, 1, 0, 0),
			mk(OP_MUL, 6, 1, 1, 0, 0),
			mk(OP_DIV, 7, 2, 3, 0, 0),      // minimum over minus one
			mk(OP_MOD, 8, 2, 3, 0, 0),
			mk(OP_DIV, 9, 1, 0, 0, 0),      // zero divisor
			mk(OP_MOD, 10, 1, 0, 0, 0),
			mk(OP_AND, 11, 1, 2, 0, 0),
			mk(OP_OR, 11, 1, 2, 0, 0),
			mk(OP_XOR, 11, 1, 3, 0, 0),
			mk(OP_SLL, 12, 3, 1, 0, 0),
			mk(OP_SRL, 13, 3, 1, 0, 0),
			mk(OP_SW, 0, 0, 1, 5, 0),
			mk(OP_LW, 14, 0, 0, 5, 0),
			mk(OP_LW, 15, 3, 0, 0, 0),      // address out of range
			mk(OP_SW, 0, 3, 1, 32'h8000_0000, 0),
			mk(OP_ADDI, 0, 1, 0, 7, 0),     // write to register zero
			mk(OP_BEQ, 0, 0, 0, 2, 0),
			mk(OP_BNE, 0, 1, 2, -1, 0),
			mk(OP_BLT, 0, 2, 1, 3, 0),
			mk(OP_BGE, 0, 2, 1, 3, 0),
			mk(OP_JAL, 16, 0, 0, 3, 0),
			mk(OP_JALR, 17, 1, 0, 32'h8000_000A, 0),
			mk(OP_PRINT, 0, 2, 0, 0, 1),
			mk(OP_HALT, 0, 0, 0, 0, 0),
			mk(OP_PRINT, 0, 1, 0, 0, 0),    // step while stopped
			mk(5'd31, 0, 0, 0, 0, 1),       // illegal opcode
			mk(OP_ADDI, 18, 0, 0, 1, 1),
			mk(OP_ADDI, 19, 0, 0, 1, 0)
		};
		foreach (dir_q[i]) send_instr(dir_q[i]);

		// pc beyond program after the length is lowered
		write_prog_len(1);
		send_instr(mk(OP_ADDI, 20, 0, 0, 3, 0));
		send_instr(mk(OP_ADDI, 20, 0, 0, 3, 1));

		// random phases
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: write_prog_len(40);
				1: write_prog_len(17'h0FFFF);
				default: write_prog_len(LenW'(LenReset));
			endcase
			idle_mode = ph;
			n = executed;
			while (executed - n < 600) begin
				if (executed - n == 300) begin
					if (ph == 0) drain();
					if (ph == 2) hold_req = 1;
				end
				it = rand_instr();
				send_instr(it);
			end
		end

		drain();
		repeat (60) @(posedge clk);
		$display("Ran %0d instructions (%0d results checked) over %0d program lengths,",
			executed, sb.checked, cfg_writes);
		$display("with divider corner cases, memory bounds and stalls on both channels.");
		if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches,
				sb.pending_q.size());
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

[mini_risc_execute_unit.f]
+incdir+rtl
rtl/mre_pkg.sv
rtl/mre_divider.sv
rtl/mini_risc_execute_unit.sv
tb/mini_risc_execute_unit_tb.sv
